[hdl/halfwidth_to_fullwidth_text_unit_macros.svh]
// assertion helpers shared by the text unit modules
`ifndef HALFWIDTH_TO_FULLWIDTH_TEXT_UNIT_MACROS_SVH
`define HALFWIDTH_TO_FULLWIDTH_TEXT_UNIT_MACROS_SVH

// checked on every clock edge outside reset
`define HFW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define HFW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/hfw_pkg.sv]
`default_nettype none

package hfw_pkg;

  // code points
  localparam logic [15:0] ASCII_FIRST = 16'h0020;
  localparam logic [15:0] ASCII_LAST  = 16'h007E;
  localparam logic [15:0] ASCII_SPACE = 16'h0020;
  localparam logic [15:0] ASCII_BSLASH = 16'h005C;
  localparam logic [15:0] ASCII_TILDE = 16'h007E;
  localparam logic [15:0] FULL_SPACE  = 16'h3000;
  localparam logic [15:0] FULL_YEN    = 16'hFFE5;
  localparam logic [15:0] FULL_MACRON = 16'hFFE3;
  localparam logic [15:0] FULL_OFFSET = 16'hFEE0;
  localparam logic [15:0] KANA_FIRST  = 16'hFF61;
  localparam logic [15:0] KANA_LAST   = 16'hFF9F;
  localparam logic [15:0] MARK_VOICED = 16'hFF9E;
  localparam logic [15:0] MARK_SEMI   = 16'hFF9F;

  // register map (word select bit of paddr)
  localparam int          ADDR_W     = 3;
  localparam logic        REG_ALPHA  = 1'b0;
  localparam logic        REG_KANA   = 1'b1;

  // output queue
  localparam int          OUTQ_DEPTH = 4;
  localparam int          OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int          OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef logic [5:0] kana_idx_t;

  typedef struct packed {
    logic [15:0] code_unit_out;
    logic        last_out;
    logic        any_converted;
  } result_t;

  // results of one item, res0 first
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } conv_out_t;

  function automatic logic takes_semi(input kana_idx_t idx);
    return (idx >= 6'h29) && (idx <= 6'h2D);
  endfunction

  function automatic logic takes_voiced(input kana_idx_t idx);
    return ((idx >= 6'h15) && (idx <= 6'h23)) || takes_semi(idx);
  endfunction

  // half-width katakana to full-width
  function automatic logic [15:0] kana_rom(input kana_idx_t idx);
    logic [15:0] v;
    unique case (idx)
      6'd0:  v = 16'h3002;  6'd1:  v = 16'h300C;  6'd2:  v = 16'h300D;
      6'd3:  v = 16'h3001;  6'd4:  v = 16'h30FB;  6'd5:  v = 16'h30F2;
      6'd6:  v = 16'h30A1;  6'd7:  v = 16'h30A3;  6'd8:  v = 16'h30A5;
      6'd9:  v = 16'h30A7;  6'd10: v = 16'h30A9;  6'd11: v = 16'h30E3;
      6'd12: v = 16'h30E5;  6'd13: v = 16'h30E7;  6'd14: v = 16'h30C3;
      6'd15: v = 16'h30FC;  6'd16: v = 16'h30A2;  6'd17: v = 16'h30A4;
      6'd18: v = 16'h30A6;  6'd19: v = 16'h30A8;  6'd20: v = 16'h30AA;
      6'd21: v = 16'h30AB;  6'd22: v = 16'h30AD;  6'd23: v = 16'h30AF;
      6'd24: v = 16'h30B1;  6'd25: v = 16'h30B3;  6'd26: v = 16'h30B5;
      6'd27: v = 16'h30B7;  6'd28: v = 16'h30B9;  6'd29: v = 16'h30BB;
      6'd30: v = 16'h30BD;  6'd31: v = 16'h30BF;  6'd32: v = 16'h30C1;
      6'd33: v = 16'h30C4;  6'd34: v = 16'h30C6;  6'd35: v = 16'h30C8;
      6'd36: v = 16'h30CA;  6'd37: v = 16'h30CB;  6'd38: v = 16'h30CC;
      6'd39: v = 16'h30CD;  6'd40: v = 16'h30CE;  6'd41: v = 16'h30CF;
      6'd42: v = 16'h30D2;  6'd43: v = 16'h30D5;  6'd44: v = 16'h30D8;
      6'd45: v = 16'h30DB;  6'd46: v = 16'h30DE;  6'd47: v = 16'h30DF;
      6'd48: v = 16'h30E0;  6'd49: v = 16'h30E1;  6'd50: v = 16'h30E2;
      6'd51: v = 16'h30E4;  6'd52: v = 16'h30E6;  6'd53: v = 16'h30E8;
      6'd54: v = 16'h30E9;  6'd55: v = 16'h30EA;  6'd56: v = 16'h30EB;
      6'd57: v = 16'h30EC;  6'd58: v = 16'h30ED;  6'd59: v = 16'h30EF;
      6'd60: v = 16'h30F3;  6'd61: v = 16'h309B;  6'd62: v = 16'h309C;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[hdl/hfw_conv.sv]
`default_nettype none
`include "halfwidth_to_fullwidth_text_unit_macros.svh"

module hfw_conv
  import hfw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        alpha_enable,
  input  wire logic        kana_enable,
  input  wire logic        fire,
  input  wire logic [15:0] code_unit,
  input  wire logic        last_in,
  output conv_out_t        conv
);

  logic        pending_valid;
  kana_idx_t   pending_kana;
  logic        converted_seen;

  logic        pending_valid_next;
  kana_idx_t   pending_kana_next;
  logic        converted_seen_next;

  logic        fuse_voiced;
  logic        fuse_semi;
  logic        done;
  logic [15:0] pend_code;
  logic        is_alpha;
  logic        is_kana;
  kana_idx_t   kidx;
  logic [15:0] kdiff;
  logic        hold;
  logic        cur_valid;
  logic [15:0] cur_code;
  logic        seen;

  // fuse a held kana with a following voicing mark
  always_comb begin
    fuse_voiced = pending_valid && kana_enable && (code_unit == MARK_VOICED)
                  && takes_voiced(pending_kana);
    fuse_semi   = pending_valid && kana_enable && (code_unit == MARK_SEMI)
                  && takes_semi(pending_kana);
    done        = fuse_voiced || fuse_semi;
    pend_code   = kana_rom(pending_kana)
                  + {14'd0, fuse_semi, fuse_voiced};
  end

  // classify and convert the current code unit
  always_comb begin
    is_alpha  = alpha_enable && (code_unit >= ASCII_FIRST) && (code_unit <= ASCII_LAST);
    is_kana   = kana_enable && (code_unit >= KANA_FIRST) && (code_unit <= KANA_LAST);
    kdiff     = code_unit - KANA_FIRST;
    kidx      = kdiff[5:0];
    hold      = !done && !is_alpha && is_kana && !last_in && takes_voiced(kidx);
    cur_valid = !done && !hold;
    seen      = converted_seen || (!done && (is_alpha || is_kana));
    priority if (is_alpha) begin
      priority if (code_unit == ASCII_SPACE) cur_code = FULL_SPACE;
      else if (code_unit == ASCII_BSLASH)    cur_code = FULL_YEN;
      else if (code_unit == ASCII_TILDE)     cur_code = FULL_MACRON;
      else                                   cur_code = code_unit + FULL_OFFSET;
    end else if (is_kana) begin
      cur_code = kana_rom(kidx);
    end else begin
      cur_code = code_unit;
    end
  end

  // pack results in order, held kana first
  always_comb begin
    conv.count = {1'b0, pending_valid} + {1'b0, cur_valid};
    conv.res0.code_unit_out = pending_valid ? pend_code : cur_code;
    conv.res0.last_out      = last_in && (conv.count == 2'd1);
    conv.res0.any_converted = last_in && (conv.count == 2'd1) && seen;
    conv.res1.code_unit_out = cur_code;
    conv.res1.last_out      = last_in;
    conv.res1.any_converted = last_in && seen;
  end

  // string state
  always_comb begin
    pending_valid_next  = pending_valid;
    pending_kana_next   = pending_kana;
    converted_seen_next = converted_seen;
    if (fire) begin
      if (last_in) begin
        pending_valid_next  = 1'b0;
        pending_kana_next   = '0;
        converted_seen_next = 1'b0;
      end else begin
        pending_valid_next  = hold;
        pending_kana_next   = hold ? kidx : '0;
        converted_seen_next = seen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid  <= 1'b0;
      pending_kana   <= '0;
      converted_seen <= 1'b0;
    end else begin
      pending_valid  <= pending_valid_next;
      pending_kana   <= pending_kana_next;
      converted_seen <= converted_seen_next;
    end
  end

  `HFW_ASSERT(a_end_clears, fire && last_in |=> !pending_valid && !converted_seen, "string end left state")
  `HFW_ASSERT(a_held_voiceable, pending_valid |-> takes_voiced(pending_kana), "held kana cannot fuse")
  `HFW_ASSERT(a_silent_holds, fire && (conv.count == 2'd0) |=> pending_valid, "item vanished")

endmodule

`default_nettype wire

[hdl/hfw_outq.sv]
`default_nettype none
`include "halfwidth_to_fullwidth_text_unit_macros.svh"

module hfw_outq
  import hfw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  conv_out_t        conv,
  output logic             room,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // code_unit_out
  output logic             m_tlast,   // last_out
  output logic             m_tuser    // any_converted
);

  result_t                 entry [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]   wr_ptr;
  logic [OUTQ_PTR_W-1:0]   rd_ptr;
  logic [OUTQ_CNT_W-1:0]   count;
  logic [OUTQ_PTR_W-1:0]   wr_ptr1;
  logic [1:0]              push_n;
  logic                    pop;
  result_t                 head;

  // queue control
  always_comb begin
    push_n   = push ? conv.count : 2'd0;
    pop      = m_tvalid && m_tready;
    room     = count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
    wr_ptr1  = wr_ptr + OUTQ_PTR_W'(1);
    m_tvalid = count != '0;
    head     = entry[rd_ptr];
    m_tdata  = head.code_unit_out;
    m_tlast  = head.last_out;
    m_tuser  = head.any_converted;
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entry[wr_ptr] <= conv.res0;
    end
    if (push_n == 2'd2) begin
      entry[wr_ptr1] <= conv.res1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUTQ_PTR_W'(push_n);
      rd_ptr <= rd_ptr + OUTQ_PTR_W'(pop);
      count  <= count + OUTQ_CNT_W'(push_n) - OUTQ_CNT_W'(pop);
    end
  end

  `HFW_ASSERT_ALWAYS(a_no_overflow, rst || (count <= OUTQ_CNT_W'(OUTQ_DEPTH)), "output queue overflow")
  `HFW_ASSERT(a_push_has_room, push |-> room, "push without room")
  `HFW_ASSERT(a_count_tracks, 1 |=> count == $past(count + OUTQ_CNT_W'(push_n) - OUTQ_CNT_W'(pop)), "count lost track")

endmodule

`default_nettype wire

[hdl/halfwidth_to_fullwidth_text_unit.sv]
// Half-width to full-width text converter. One UTF-16 code unit per item on
// the s_ stream, converted items on the m_ stream, one item per clock in both
// directions while the queue has room and m_tready is high. Printable ASCII
// turns into its full-width form and half-width katakana into full-width
// katakana; a voiceable kana that does not end the string is held back one
// item so a following voiced or semi-voiced mark fuses into it, so such a
// kana shows up at the output only with the next item. A kana that does not
// fuse comes out ahead of the next item's result, and that input item then
// yields two results: the four-entry output queue absorbs them and the input
// stalls only if the queue is backed up. m_tuser carries on the tlast item
// whether anything in the string was converted. Registers alpha_enable
// (0x0) and kana_enable (0x4), both reset to 1, must be written only while
// the unit is idle; the unit itself does not enforce this.
`default_nettype none

module halfwidth_to_fullwidth_text_unit
  import hfw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [15:0]       s_tdata,   // code_unit
  input  wire logic              s_tlast,   // last_in
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [15:0]            m_tdata,   // code_unit_out
  output logic                   m_tlast,   // last_out
  output logic                   m_tuser,   // any_converted
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic        alpha_enable;
  logic        kana_enable;
  logic        cfg_write;
  logic        in_valid;
  logic [15:0] in_code;
  logic        in_last;
  logic        fire;
  logic        room;
  conv_out_t   conv;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_enable <= 1'b1;
      kana_enable  <= 1'b1;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_ALPHA: alpha_enable <= pwdata[0];
        REG_KANA:  kana_enable  <= pwdata[0];
        default:   alpha_enable <= alpha_enable;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ALPHA: prdata = {31'd0, alpha_enable};
      REG_KANA:  prdata = {31'd0, kana_enable};
      default:   prdata = '0;
    endcase
  end

  // input register
  assign fire     = in_valid && room;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_code <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // conversion
  hfw_conv u_conv (
    .clk          (clk),
    .rst          (rst),
    .alpha_enable (alpha_enable),
    .kana_enable  (kana_enable),
    .fire         (fire),
    .code_unit    (in_code),
    .last_in      (in_last),
    .conv         (conv)
  );

  // result queue
  hfw_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (fire),
    .conv     (conv),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
